### rtl/stable_sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue checker.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
// same-cycle implication, sampled on clk, off during reset
`define SSPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sspq check failed");
// next-cycle implication
`define SSPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sspq check failed");
`endif

### rtl/sspq_pkg.sv
// Shared types and constants of the sorted priority queue.
package sspq_pkg;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int ID_COUNT_DEF    = 256;
	localparam int MAX_MATCH_DEF   = 12;
	localparam logic [3:0] MATCH_SIZE_RST = 4'd12;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_MATCH  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_INS_PUT,
		S_POP_RD,
		S_POP_OUT
	} state_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] key;
	} entry_t;
endpackage

### rtl/stable_sorted_priority_queue.sv
// Stable sorted priority queue built on a circular entry RAM and an id mark RAM.
// Command channel: start with command, player_id and key is taken when busy is low.
// Results appear on result_valid for one cycle each; the receiver cannot stall,
// so every result is delivered the cycle it is shown.
// Config: cfg_valid/cfg_ready write the match limit (always ready; write only when idle).
// Entries live in a circular buffer RAM (head pointer + count), kept in descending
// key order; equal keys keep arrival order.
// Insert: the id mark is read first, then each entry that has a smaller key
//   is walked from the tail and shifted up one slot; a compare against a key
//   at least as large, or reaching the head, stops the walk, and the new entry
//   is put in the freed slot. A duplicate or full answer comes straight from
//   the mark check, without the walk.
// Remove: the head entry is read, then given as its result. Match: pops
//   entries one by one, the last result carrying spread and match_count.
// Remove or match on an empty queue answers straight from idle with status empty.
// The entry RAM's single read port sets the pace of the insert walk.
// After reset the mark RAM is swept to zero, one id per cycle; busy stays
// high meanwhile. Config writes are taken at any time.
module stable_sorted_priority_queue import sspq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_COUNT    = ID_COUNT_DEF,
	parameter int MAX_MATCH   = MAX_MATCH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  player_id,
	input  logic [15:0] key,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output logic        result_valid,
	output logic [1:0]  status,
	output logic [7:0]  out_id,
	output logic [15:0] out_key,
	output logic        last,
	output logic [15:0] spread,
	output logic [3:0]  match_count
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

	state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d, p_q, p_d;
	logic [3:0]    n_q, n_d;
	logic [15:0]   top_q, top_d;
	logic [IW-1:0] clr_q, clr_d;
	logic [1:0]    cmd_q, cmd_d;
	logic [7:0]    id_q, id_d;
	logic [15:0]   key_q, key_d;
	logic [3:0]    msize_q;

	logic        rv_d;
	logic [1:0]  status_d;
	logic [7:0]  oid_d;
	logic [15:0] okey_d, spread_d, top_now;
	logic        last_d, fin;
	logic [3:0]  mc_d, limit, ms;

	logic          e_we;
	logic [AW-1:0] e_waddr, e_raddr;
	entry_t        e_wdata, e_rdata;
	logic          m_we, m_wdata, m_rdata;
	logic [IW-1:0] m_waddr, m_raddr;

	logic [IW-1:0] id_tab [256];

	// id folded into the mark range, worked out at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_idtab
		assign id_tab[g] = IW'(g % ID_COUNT);
	end

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
		logic [AW:0] s;
		s = (AW+1)'(h) + (AW+1)'(l);
		if (s >= (AW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	sspq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	sspq_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_mark_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign ms    = (msize_q == 4'd0) ? 4'd1 : msize_q;
	assign limit = (7'(ms) > 7'(MAX_MATCH)) ? 4'(MAX_MATCH) : ms;
	assign top_now = (n_q == 4'd0) ? e_rdata.key : top_q;
	assign fin = (cmd_q == CMD_REMOVE) || (n_q + 4'd1 == limit) || (count_q == CW'(1));

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		p_d = p_q;
		n_d = n_q;
		top_d = top_q;
		clr_d = clr_q;
		cmd_d = cmd_q;
		id_d = id_q;
		key_d = key_q;
		rv_d = 1'b0;
		status_d = ST_OK;
		oid_d = 8'd0;
		okey_d = 16'd0;
		last_d = 1'b1;
		spread_d = 16'd0;
		mc_d = 4'd0;
		e_we = 1'b0;
		e_waddr = head_q;
		e_wdata = '{id: id_q, key: key_q};
		e_raddr = head_q;
		m_we = 1'b0;
		m_waddr = clr_q;
		m_wdata = 1'b0;
		m_raddr = id_tab[player_id];
		case (state_q)
			S_CLEAR: begin
				m_we = 1'b1;
				clr_d = clr_q + IW'(1);
				if (clr_q == IW'(ID_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd_d = command;
					id_d = player_id;
					key_d = key;
					n_d = 4'd0;
					if (command == CMD_INSERT) begin
						state_d = S_INS_CHK;
					end else if (command == CMD_REMOVE || command == CMD_MATCH) begin
						if (count_q == CW'(0)) begin
							rv_d = 1'b1;
							status_d = ST_EMPTY;
						end else begin
							state_d = S_POP_RD;
						end
					end
				end
			end
			S_INS_CHK: begin
				e_raddr = phys(head_q, count_q - CW'(1));
				p_d = count_q;
				if (m_rdata) begin
					rv_d = 1'b1;
					status_d = ST_DUP;
					state_d = S_IDLE;
				end else if (count_q == CW'(QUEUE_DEPTH)) begin
					rv_d = 1'b1;
					status_d = ST_FULL;
					state_d = S_IDLE;
				end else if (count_q == CW'(0)) begin
					state_d = S_INS_PUT;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				// walk from the tail; shift smaller keys up one slot
				e_raddr = phys(head_q, p_q - CW'(2));
				if (e_rdata.key >= key_q) begin
					state_d = S_INS_PUT;
				end else begin
					e_we = 1'b1;
					e_waddr = phys(head_q, p_q);
					e_wdata = e_rdata;
					p_d = p_q - CW'(1);
					if (p_q == CW'(1)) begin
						state_d = S_INS_PUT;
					end
				end
			end
			S_INS_PUT: begin
				e_we = 1'b1;
				e_waddr = phys(head_q, p_q);
				m_we = 1'b1;
				m_waddr = id_tab[id_q];
				m_wdata = 1'b1;
				count_d = count_q + CW'(1);
				rv_d = 1'b1;
				state_d = S_IDLE;
			end
			S_POP_RD: begin
				state_d = S_POP_OUT;
			end
			S_POP_OUT: begin
				m_we = 1'b1;
				m_waddr = id_tab[e_rdata.id];
				head_d = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_d = count_q - CW'(1);
				n_d = n_q + 4'd1;
				top_d = top_now;
				rv_d = 1'b1;
				oid_d = e_rdata.id;
				okey_d = e_rdata.key;
				last_d = fin;
				if (fin && cmd_q == CMD_MATCH) begin
					spread_d = top_now - e_rdata.key;
					mc_d = n_q + 4'd1;
				end
				state_d = fin ? S_IDLE : S_POP_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			clr_q <= '0;
			msize_q <= MATCH_SIZE_RST;
			result_valid <= 1'b0;
		end else begin
			head_q <= head_d;
			count_q <= count_d;
			clr_q <= clr_d;
			result_valid <= rv_d;
			if (cfg_valid && cfg_ready) begin
				msize_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q <= p_d;
		n_q <= n_d;
		top_q <= top_d;
		cmd_q <= cmd_d;
		id_q <= id_d;
		key_q <= key_d;
		if (rv_d) begin
			status <= status_d;
			out_id <= oid_d;
			out_key <= okey_d;
			last <= last_d;
			spread <= spread_d;
			match_count <= mc_d;
		end
	end
endmodule

### rtl/sspq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sspq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/sspq_check.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`include "stable_sorted_priority_queue_macros.svh"
module sspq_check import sspq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  command,
	input logic [7:0]  player_id,
	input logic [15:0] key,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [3:0]  cfg_data,
	input logic        result_valid,
	input logic [1:0]  status,
	input logic [7:0]  out_id,
	input logic [15:0] out_key,
	input logic        last,
	input logic [15:0] spread,
	input logic [3:0]  match_count
);
	// error statuses always end the command
	`SSPQ_ASSERT_NOW(a_err_last, result_valid && status != ST_OK, last)
	// an empty answer carries no entry
	`SSPQ_ASSERT_NOW(a_empty_zero, result_valid && status == ST_EMPTY, out_id == 8'd0 && out_key == 16'd0)
	// an intermediate match beat is followed by more work
	`SSPQ_ASSERT_NOW(a_mid_busy, result_valid && !last, busy)
	// an idle accept of a match command is followed by busy or by a final (last) result
	`SSPQ_ASSERT_NEXT(a_empty_fast, start && !busy && command == CMD_MATCH, busy || (result_valid && last))
endmodule

bind stable_sorted_priority_queue sspq_check u_sspq_check (.*);

### dv/tb_top.sv
// Testbench for the stable sorted priority queue: directed table plus random traffic.
`timescale 1ns / 100ps
module tb_top;
	import sspq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int IDS = ID_COUNT_DEF;
	localparam int MAXM = MAX_MATCH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	// command code with no meaning; the block ignores it
	localparam logic [1:0] CMD_NOP = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  id;
		logic [15:0] key;
		logic        last;
		logic [15:0] spread;
		logic [3:0]  count;
	} qresult_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  id;
		logic [15:0] key;
		logic        fixed;
		qresult_t    res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] command = '0;
	logic [7:0] player_id = '0;
	logic [15:0] key = '0;
	logic cfg_valid = 1'b0;
	logic [3:0] cfg_data = '0;
	logic busy, cfg_ready, result_valid, last;
	logic [1:0] status;
	logic [7:0] out_id;
	logic [15:0] out_key, spread;
	logic [3:0] match_count;

	stable_sorted_priority_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .player_id(player_id), .key(key),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .status(status), .out_id(out_id),
		.out_key(out_key), .last(last), .spread(spread), .match_count(match_count)
	);

	always #5 clk = ~clk;

	// shadow queue state
	logic [7:0]  q_id[$];
	logic [15:0] q_key[$];
	bit          marked[IDS];
	logic [3:0]  msize;
	qresult_t    pending[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;

	function automatic qresult_t mk(logic [1:0] s, logic [7:0] i, logic [15:0] k,
		logic l, logic [15:0] sp, logic [3:0] c);
		qresult_t r;
		r.status = s; r.id = i; r.key = k; r.last = l; r.spread = sp; r.count = c;
		return r;
	endfunction

	task automatic predict_queue(logic [1:0] cmd, logic [7:0] id, logic [15:0] k);
		int pos, lim, n;
		logic [15:0] top;
		logic [7:0] pid;
		logic [15:0] pkey;
		if (cmd == CMD_INSERT) begin
			if (marked[id]) pending.push_back(mk(ST_DUP, '0, '0, 1'b1, '0, '0));
			else if (q_id.size() >= DEPTH) pending.push_back(mk(ST_FULL, '0, '0, 1'b1, '0, '0));
			else begin
				pos = 0;
				while (pos < q_key.size() && q_key[pos] >= k) pos++;
				q_id.insert(pos, id);
				q_key.insert(pos, k);
				marked[id] = 1'b1;
				pending.push_back(mk(ST_OK, '0, '0, 1'b1, '0, '0));
			end
		end else if (cmd == CMD_REMOVE || cmd == CMD_MATCH) begin
			lim = (cmd == CMD_REMOVE) ? 1 :
				(msize == 4'd0 ? 1 : (int'(msize) > MAXM ? MAXM : int'(msize)));
			if (q_id.size() == 0) pending.push_back(mk(ST_EMPTY, '0, '0, 1'b1, '0, '0));
			else begin
				n = q_id.size() < lim ? q_id.size() : lim;
				top = q_key[0];
				for (int i = 0; i < n; i++) begin
					pid = q_id.pop_front();
					pkey = q_key.pop_front();
					marked[pid] = 1'b0;
					if (i + 1 < n) pending.push_back(mk(ST_OK, pid, pkey, 1'b0, '0, '0));
					else if (cmd == CMD_REMOVE)
						pending.push_back(mk(ST_OK, pid, pkey, 1'b1, '0, '0));
					else pending.push_back(mk(ST_OK, pid, pkey, 1'b1, top - pkey, 4'(n)));
				end
			end
		end
	endtask

	// result checker; receiver never stalls
	always @(posedge clk) begin
		qresult_t got, want;
		cycles <= cycles + 1;
		if (arst_n && result_valid) begin
			got = mk(status, out_id, out_key, last, spread, match_count);
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				errors <= errors + 1;
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					errors <= errors + 1;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// start stays up after the accepting edge; the next idle cycle or drain drops it
	task automatic send_beat(logic [1:0] cmd, logic [7:0] id, logic [15:0] k);
		while (!quiet && $urandom_range(99) < 17) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1; command <= cmd; player_id <= id; key <= k;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_queue(cmd, id, k);
	endtask

	task automatic drain_wait();
		start <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_size(logic [3:0] v);
		drain_wait();
		cfg_valid <= 1'b1; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		msize = v;
	endtask

	row_t rows[$];
	logic [1:0] rc;
	logic [7:0] rid;
	int r;
	logic [3:0] msize_list[5] = '{4'd0, 4'd1, 4'd15, 4'd7, 4'd12};

	function automatic row_t row(logic [1:0] c, logic [7:0] i, logic [15:0] k,
		logic f, qresult_t e);
		row_t x;
		x.cmd = c; x.id = i; x.key = k; x.fixed = f; x.res = e;
		return x;
	endfunction

	initial begin
		msize = MATCH_SIZE_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		rows.push_back(row(CMD_REMOVE, '0, '0, 1'b1, mk(ST_EMPTY, '0, '0, 1'b1, '0, '0)));
		rows.push_back(row(CMD_MATCH, '0, '0, 1'b1, mk(ST_EMPTY, '0, '0, 1'b1, '0, '0)));
		rows.push_back(row(CMD_INSERT, 8'hFF, 16'hFFFF, 1'b1, mk(ST_OK, '0, '0, 1'b1, '0, '0)));
		rows.push_back(row(CMD_INSERT, 8'hFF, 16'h0001, 1'b1, mk(ST_DUP, '0, '0, 1'b1, '0, '0)));
		rows.push_back(row(CMD_REMOVE, '0, '0, 1'b1,
			mk(ST_OK, 8'hFF, 16'hFFFF, 1'b1, '0, '0)));
		rows.push_back(row(CMD_INSERT, 8'h00, 16'h0000, 1'b0, '0));
		rows.push_back(row(CMD_INSERT, 8'h01, 16'h8000, 1'b0, '0));
		rows.push_back(row(CMD_INSERT, 8'h02, 16'h8000, 1'b0, '0)); // equal keys keep order
		rows.push_back(row(CMD_INSERT, 8'hAA, 16'h5555, 1'b0, '0));
		rows.push_back(row(CMD_INSERT, 8'h55, 16'hAAAA, 1'b0, '0));
		rows.push_back(row(CMD_NOP, 8'h12, 16'h1234, 1'b0, '0)); // ignored command
		rows.push_back(row(CMD_MATCH, '0, '0, 1'b0, '0));
		rows.push_back(row(CMD_MATCH, '0, '0, 1'b1, mk(ST_EMPTY, '0, '0, 1'b1, '0, '0)));
		foreach (rows[i]) begin
			send_beat(rows[i].cmd, rows[i].id, rows[i].key);
			if (rows[i].fixed && rows[i].cmd != CMD_NOP) begin
				pending.pop_back();
				pending.push_back(rows[i].res);
			end
		end
		// fill to full, hit the full flag, then match out at several sizes
		for (int i = 0; i < DEPTH; i++)
			send_beat(CMD_INSERT, 8'(i), 16'($urandom_range(3)) * 16'h4000);
		send_beat(CMD_INSERT, 8'hF0, 16'h1234);
		foreach (msize_list[j]) begin
			write_size(msize_list[j]);
			send_beat(CMD_MATCH, '0, '0);
		end
		// random phases; third one runs without idling
		for (int ph = 0; ph < 4; ph++) begin
			write_size(4'($urandom_range(15)));
			quiet = (ph == 2);
			for (int n = 0; n < 32; n++) begin
				r = $urandom_range(99);
				rc = r < 55 ? CMD_INSERT : (r < 75 ? CMD_REMOVE : (r < 95 ? CMD_MATCH : CMD_NOP));
				rid = (ph == 3) ? 8'($urandom_range(20)) : 8'($urandom_range(255));
				send_beat(rc, rid, ph == 1 ? 16'($urandom_range(7)) : 16'($urandom_range(16'hFFFF)));
			end
			quiet = 0;
		end
		write_size(MATCH_SIZE_RST);
		send_beat(CMD_MATCH, '0, '0);
		drain_wait();
		if (errors == 0 && pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
